### design/deq_pkg.sv
// Shared types, codes and defaults for the deadline-ordered event queue.
package deq_pkg;

    // Default number of queue cells
    localparam int DEPTH_DEF = 16;

    // Field widths fixed by the transaction format
    localparam int DL_W   = 33;
    localparam int TIME_W = 32;
    localparam int KIND_W = 3;
    localparam int DATA_W = 32;
    localparam int MODE_W = 2;
    localparam int STAT_W = 3;

    // Operation codes
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_POP = 1'b1;

    // Insert modes (code 3 behaves as keep)
    localparam logic [MODE_W-1:0] MODE_PLAIN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEEP    = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_KEPT     = 3'd1;
    localparam logic [STAT_W-1:0] ST_REPLACED = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_POPPED   = 3'd4;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd5;

    // One queued event
    typedef struct packed {
        logic [DL_W-1:0]          deadline;
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] data;
    } t_entry;

    // Command broadcast to every cell
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_REMOVE,
        CMD_INSERT
    } t_cell_cmd;

    // Broadcast control: command plus the event being added or matched
    typedef struct packed {
        t_cell_cmd cmd;
        t_entry    ins;
    } t_cell_ctrl;

endpackage

### design/deq_if.sv
// Valid/ready channel interfaces for queue requests and results.
interface deq_in_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [TIME_W-1:0]        now;
    logic [KIND_W-1:0]        event_kind;
    logic signed [DATA_W-1:0] event_data;
    logic [TIME_W-1:0]        delay;
    logic [MODE_W-1:0]        insert_mode;

    modport source (
        output valid, op, now, event_kind, event_data, delay, insert_mode,
        input  ready
    );
    modport sink (
        input  valid, op, now, event_kind, event_data, delay, insert_mode,
        output ready
    );
endinterface

interface deq_out_if #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [KIND_W-1:0]        out_kind;
    logic signed [DATA_W-1:0] out_data;
    logic [DL_W-1:0]          out_deadline;
    logic [CNT_W-1:0]         entry_count;
    logic [DL_W-1:0]          head_deadline;
    logic                     head_due;

    modport source (
        output valid, status, out_kind, out_data, out_deadline, entry_count,
               head_deadline, head_due,
        input  ready
    );
    modport sink (
        input  valid, status, out_kind, out_data, out_deadline, entry_count,
               head_deadline, head_due,
        output ready
    );
endinterface

### design/deq_cell.sv
// One queue cell: holds an event and shifts left or right with its neighbors.
module deq_cell (
    input  logic                i_clk,
    input  deq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occ,
    input  deq_pkg::t_entry     i_left,
    input  logic                i_left_ge,
    input  deq_pkg::t_entry     i_right,
    input  logic                i_sh,
    output deq_pkg::t_entry     o_entry,
    output logic                o_ge,
    output logic                o_sh,
    output logic                o_match
);
    import deq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Same kind and data as the broadcast event
    assign o_match = i_occ && (r_entry.kind == i_ctrl.ins.kind)
                           && (r_entry.data == i_ctrl.ins.data);

    // Insertion boundary: free cell or deadline at/after the new one
    assign o_ge = !i_occ || (r_entry.deadline >= i_ctrl.ins.deadline);

    // Removal chain: this cell and all after it pull from the right
    assign o_sh = i_sh || o_match;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.cmd)
            CMD_REMOVE: begin
                if (o_sh) begin
                    n_entry = i_right;
                end
            end
            CMD_INSERT: begin
                if (o_ge && !i_left_ge) begin
                    n_entry = i_ctrl.ins;
                end else if (o_ge) begin
                    n_entry = i_left;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

### design/deadline_ordered_event_queue_core.sv
// Accept to result valid: a pop goes through pop and result, a keep with a match through
// scan and result, other adds through scan, insert and result, plus one more scan step
// per duplicate removed in replace mode. Throughput: one request in flight; ready returns
// as the result is registered, and stays low while the output is stalled.
// Reset (synchronous, active low) empties the queue and clears the output valid;
// cell contents are not reset, occupancy comes from the held count.
module deadline_ordered_event_queue_core #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    deq_in_if.sink    i_in,
    deq_out_if.source o_out
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INSERT,
        S_POP,
        S_RESULT
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_op;
    logic [TIME_W-1:0]        r_now;
    logic [MODE_W-1:0]        r_mode;
    t_entry                   r_ins;
    logic                     r_removed, n_removed;
    logic [STAT_W-1:0]        r_status, n_status;
    t_entry                   r_pop, n_pop;

    // Output register
    logic                     r_ovalid, n_ovalid;
    logic [STAT_W-1:0]        r_o_status;
    t_entry                   r_o_pop;
    logic [CNT_W-1:0]         r_o_count;
    logic [DL_W-1:0]          r_o_head;
    logic                     r_o_due;

    // Cell chain links
    t_cell_ctrl               w_ctrl;
    logic                     w_sh0;
    t_entry                   w_entry [DEPTH];
    logic [DEPTH-1:0]         w_ge;
    logic [DEPTH-1:0]         w_sh;
    logic [DEPTH-1:0]         w_match;
    logic [DEPTH-1:0]         w_occ;
    logic                     w_any_match;
    logic                     w_accept;
    logic [DL_W-1:0]          w_now_ext;
    logic [DL_W-1:0]          w_head;
    logic                     w_due;

    assign w_accept    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_any_match = |w_match;
    assign w_now_ext   = {1'b0, r_now};

    // Thermometer occupancy from the held count
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_occ[i] = (CNT_W'(i) < r_count);
        end
    end

    // Cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_ge;
        logic   w_sh_in;

        if (g == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_ge = 1'b0;
            assign w_sh_in   = w_sh0;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_ge = w_ge[g-1];
            assign w_sh_in   = w_sh[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        deq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_occ     (w_occ[g]),
            .i_left    (w_left),
            .i_left_ge (w_left_ge),
            .i_right   (w_right),
            .i_sh      (w_sh_in),
            .o_entry   (w_entry[g]),
            .o_ge      (w_ge[g]),
            .o_sh      (w_sh[g]),
            .o_match   (w_match[g])
        );
    end

    // Head summary after the update
    assign w_head = (r_count != '0) ? w_entry[0].deadline : w_now_ext;
    assign w_due  = (r_count != '0) && (w_entry[0].deadline <= w_now_ext);

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_removed  = r_removed;
        n_status   = r_status;
        n_pop      = r_pop;
        n_ovalid   = r_ovalid;
        w_ctrl.cmd = CMD_HOLD;
        w_ctrl.ins = r_ins;
        w_sh0      = 1'b0;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_removed = 1'b0;
                    n_pop     = '0;
                    n_state   = (i_in.op == OP_POP) ? S_POP : S_SCAN;
                end
            end
            S_POP: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status   = ST_POPPED;
                    n_pop      = w_entry[0];
                    w_ctrl.cmd = CMD_REMOVE;
                    w_sh0      = 1'b1;
                    n_count    = r_count - CNT_W'(1);
                end
                n_state = S_RESULT;
            end
            S_SCAN: begin
                if (r_mode == MODE_PLAIN || !w_any_match) begin
                    n_state = S_INSERT;
                end else if (r_mode == MODE_REPLACE) begin
                    // drop one duplicate per cycle until none remain
                    w_ctrl.cmd = CMD_REMOVE;
                    n_count    = r_count - CNT_W'(1);
                    n_removed  = 1'b1;
                end else begin
                    n_status = ST_KEPT;
                    n_state  = S_RESULT;
                end
            end
            S_INSERT: begin
                if (r_count == CNT_W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.cmd = CMD_INSERT;
                    n_count    = r_count + CNT_W'(1);
                    n_status   = r_removed ? ST_REPLACED : ST_INSERTED;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, count and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end

        r_removed <= n_removed;
        r_status  <= n_status;
        r_pop     <= n_pop;

        if (w_accept) begin
            r_op           <= i_in.op;
            r_now          <= i_in.now;
            r_mode         <= i_in.insert_mode;
            r_ins.kind     <= i_in.event_kind;
            r_ins.data     <= i_in.event_data;
            r_ins.deadline <= {1'b0, i_in.now} + {1'b0, i_in.delay};
        end

        if (r_state == S_RESULT && (!r_ovalid || o_out.ready)) begin
            r_o_status <= r_status;
            r_o_pop    <= (r_op == OP_POP) ? r_pop : '0;
            r_o_count  <= r_count;
            r_o_head   <= w_head;
            r_o_due    <= w_due;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.status        = r_o_status;
    assign o_out.out_kind      = r_o_pop.kind;
    assign o_out.out_data      = r_o_pop.data;
    assign o_out.out_deadline  = r_o_pop.deadline;
    assign o_out.entry_count   = r_o_count;
    assign o_out.head_deadline = r_o_head;
    assign o_out.head_due      = r_o_due;

endmodule

### bench/tb_deadline_ordered_event_queue_core.sv
// Self-checking testbench for the deadline-ordered event queue core.
module tb_deadline_ordered_event_queue_core;
    import deq_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CAP      = 100000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int PHASE_ITEMS    = 400;

    // One request as offered on the input channel
    typedef struct packed {
        logic                     op;
        logic [TIME_W-1:0]        now;
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] data;
        logic [TIME_W-1:0]        delay;
        logic [MODE_W-1:0]        mode;
    } t_evq_req;

    // One result as seen on the output channel
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [KIND_W-1:0]        out_kind;
        logic signed [DATA_W-1:0] out_data;
        logic [DL_W-1:0]          out_deadline;
        logic [CNT_W-1:0]         entry_count;
        logic [DL_W-1:0]          head_deadline;
        logic                     head_due;
    } t_evq_result;

    logic clk = 1'b0;
    logic rst_n;

    deq_in_if                  in_ch ();
    deq_out_if #(.DEPTH(DEPTH)) out_ch ();

    deadline_ordered_event_queue_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Shadow copy of the sorted queue
    logic [DL_W-1:0]   sh_deadline [DEPTH];
    logic [KIND_W-1:0] sh_kind     [DEPTH];
    logic [DATA_W-1:0] sh_data     [DEPTH];
    int                sh_count;

    t_evq_result pending_results [$];

    int          mismatches;
    int          requests_sent;
    int          results_checked;
    int          status_seen [8];
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          rx_hold_req;
    logic [TIME_W-1:0] wall_now;

    // Clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #6000000;
        $display("simulation failed");
        $finish;
    end

    // Receiver ready: random stalls, plus a long hold-off on request
    initial begin : rx_ready_gen
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_seen != rx_hold_req) begin
                hold_seen = rx_hold_req;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Remove one entry and close the gap
    function automatic void drop_slot(int pos);
        for (int j = pos; j + 1 < sh_count; j++) begin
            sh_deadline[j] = sh_deadline[j + 1];
            sh_kind[j]     = sh_kind[j + 1];
            sh_data[j]     = sh_data[j + 1];
        end
        sh_count--;
    endfunction

    // Apply one request to the shadow queue and return the result it causes
    function automatic t_evq_result queue_apply(t_evq_req r);
        t_evq_result     res;
        logic [DL_W-1:0] dl;
        logic [DL_W-1:0] now33;
        bit              removed;
        bit              matched;
        int              i;
        int              pos;
        res     = '0;
        removed = 1'b0;
        matched = 1'b0;
        now33   = {1'b0, r.now};
        if (r.op == OP_POP) begin
            if (sh_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.status       = ST_POPPED;
                res.out_kind     = sh_kind[0];
                res.out_data     = sh_data[0];
                res.out_deadline = sh_deadline[0];
                drop_slot(0);
            end
        end else begin
            dl = now33 + {1'b0, r.delay};
            if (r.mode == MODE_REPLACE) begin
                i = 0;
                while (i < sh_count) begin
                    if (sh_kind[i] == r.kind && sh_data[i] == r.data) begin
                        drop_slot(i);
                        removed = 1'b1;
                    end else begin
                        i++;
                    end
                end
            end else if (r.mode != MODE_PLAIN) begin
                // keep mode, and the unused code that acts as keep
                for (i = 0; i < sh_count; i++) begin
                    if (sh_kind[i] == r.kind && sh_data[i] == r.data)
                        matched = 1'b1;
                end
            end
            if (matched) begin
                res.status = ST_KEPT;
            end else if (sh_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // new event goes ahead of equal deadlines
                pos = 0;
                while (pos < sh_count && sh_deadline[pos] < dl)
                    pos++;
                for (i = sh_count; i > pos; i--) begin
                    sh_deadline[i] = sh_deadline[i - 1];
                    sh_kind[i]     = sh_kind[i - 1];
                    sh_data[i]     = sh_data[i - 1];
                end
                sh_deadline[pos] = dl;
                sh_kind[pos]     = r.kind;
                sh_data[pos]     = r.data;
                sh_count++;
                res.status = removed ? ST_REPLACED : ST_INSERTED;
            end
        end
        res.entry_count   = CNT_W'(sh_count);
        res.head_deadline = (sh_count != 0) ? sh_deadline[0] : now33;
        res.head_due      = (sh_count != 0) && (sh_deadline[0] <= now33);
        return res;
    endfunction

    function automatic t_evq_req make_req(logic op, logic [TIME_W-1:0] now,
                                          logic [KIND_W-1:0] kind, logic [DATA_W-1:0] data,
                                          logic [TIME_W-1:0] delay, logic [MODE_W-1:0] mode);
        t_evq_req r;
        r.op    = op;
        r.now   = now;
        r.kind  = kind;
        r.data  = data;
        r.delay = delay;
        r.mode  = mode;
        return r;
    endfunction

    // Random request; small kind/data space so duplicates are common
    function automatic t_evq_req rand_req(int add_pct);
        t_evq_req r;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 3)
            wall_now = $urandom();
        else if (pick < 5)
            wall_now = 32'hFFFF_FFF0 + $urandom_range(15);
        else
            wall_now = wall_now + $urandom_range(3);
        r.op   = ($urandom_range(99) < add_pct) ? OP_ADD : OP_POP;
        r.now  = wall_now;
        r.kind = KIND_W'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 55) begin
            r.data = $urandom_range(3);
        end else if (pick < 75) begin
            case ($urandom_range(4))
                0:       r.data = 32'h7FFF_FFFF;
                1:       r.data = 32'h8000_0000;
                2:       r.data = 32'hFFFF_FFFF;
                3:       r.data = 32'h0000_0001;
                default: r.data = 32'h0000_0000;
            endcase
        end else begin
            r.data = $urandom();
        end
        pick = $urandom_range(99);
        if (pick < 60)
            r.delay = $urandom_range(15);
        else if (pick < 80)
            r.delay = $urandom_range(1000);
        else
            r.delay = $urandom();
        r.mode = MODE_W'($urandom_range(3));
        return r;
    endfunction

    // Offer one request, with random idle cycles first; predict at acceptance
    task automatic offer_request(t_evq_req r);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= r.op;
        in_ch.now         <= r.now;
        in_ch.event_kind  <= r.kind;
        in_ch.event_data  <= r.data;
        in_ch.delay       <= r.delay;
        in_ch.insert_mode <= r.mode;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_results.push_back(queue_apply(r));
        requests_sent++;
    endtask

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Result checker
    always @(posedge clk) begin : result_check
        t_evq_result want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, status %0h", $time, out_ch.status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", 64'(want.status), 64'(out_ch.status));
                compare_field("out_kind", 64'(want.out_kind), 64'(out_ch.out_kind));
                compare_field("out_data", 64'($unsigned(want.out_data)),
                              64'($unsigned(out_ch.out_data)));
                compare_field("out_deadline", 64'(want.out_deadline),
                              64'(out_ch.out_deadline));
                compare_field("entry_count", 64'(want.entry_count), 64'(out_ch.entry_count));
                compare_field("head_deadline", 64'(want.head_deadline),
                              64'(out_ch.head_deadline));
                compare_field("head_due", 64'(want.head_due), 64'(out_ch.head_due));
                status_seen[want.status]++;
                results_checked++;
            end
        end
    end

    task automatic run_reset();
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    // Empty pop, extreme fields, unique modes and tie order
    task automatic test_unique_modes();
        offer_request(make_req(OP_POP, 32'd0, 3'd0, 32'd0, 32'd0, MODE_PLAIN));
        // largest deadline: now and delay both at maximum
        offer_request(make_req(OP_ADD, 32'hFFFF_FFFF, 3'd7, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                               MODE_PLAIN));
        // zero deadline, due at once
        offer_request(make_req(OP_ADD, 32'd0, 3'd0, 32'h8000_0000, 32'd0, MODE_PLAIN));
        offer_request(make_req(OP_ADD, 32'd1, 3'd0, 32'h8000_0000, 32'd9, MODE_KEEP));
        offer_request(make_req(OP_ADD, 32'd0, 3'd0, 32'h8000_0000, 32'd5, MODE_REPLACE));
        // unused mode code acts as keep
        offer_request(make_req(OP_ADD, 32'd3, 3'd7, 32'h7FFF_FFFF, 32'd1, 2'd3));
        // same deadline as an existing entry: goes ahead of it
        offer_request(make_req(OP_ADD, 32'd0, 3'd1, 32'd5, 32'd5, MODE_PLAIN));
        offer_request(make_req(OP_POP, 32'd2, 3'd0, 32'd0, 32'd0, MODE_PLAIN));
    endtask

    // Fill to capacity, then every add path against a full queue
    task automatic test_full_queue();
        logic [DATA_W-1:0] d;
        for (int i = 0; i < DEPTH - 2; i++) begin
            d = (i == DEPTH - 3) ? 32'hFFFF_FFFF : i * 32'h1357_9BDF;
            offer_request(make_req(OP_ADD, 32'd100, KIND_W'(i), d, TIME_W'((i * 7) % 13),
                                   MODE_PLAIN));
        end
        offer_request(make_req(OP_ADD, 32'd101, 3'd2, 32'd99, 32'd4, MODE_PLAIN));
        offer_request(make_req(OP_ADD, 32'd101, 3'd7, 32'h7FFF_FFFF, 32'd4, MODE_KEEP));
        offer_request(make_req(OP_ADD, 32'd101, 3'd0, 32'h8000_0000, 32'd2, MODE_REPLACE));
        offer_request(make_req(OP_ADD, 32'd101, 3'd3, 32'd77, 32'd2, MODE_REPLACE));
        offer_request(make_req(OP_ADD, 32'd101, 3'd4, 32'd78, 32'd2, MODE_KEEP));
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req++;
        for (int n = 0; n < 30; n++)
            offer_request(rand_req(60));
    endtask

    // Random traffic; add ratio swings so the queue fills and drains
    task automatic test_random_traffic(int tx_pct, int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int n = 0; n < PHASE_ITEMS; n++)
            offer_request(rand_req(((n / 40) % 2) ? 30 : 75));
    endtask

    task automatic wait_drain();
        int waited;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_CAP) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Test sequence
    initial begin
        mismatches      = 0;
        requests_sent   = 0;
        results_checked = 0;
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        rx_hold_req     = 0;
        wall_now        = '0;
        sh_count        = 0;
        foreach (status_seen[k])
            status_seen[k] = 0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_ADD;
        in_ch.now         <= '0;
        in_ch.event_kind  <= '0;
        in_ch.event_data  <= '0;
        in_ch.delay       <= '0;
        in_ch.insert_mode <= MODE_PLAIN;

        run_reset();
        test_unique_modes();
        test_full_queue();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(78, 0);
        test_random_traffic(0, 78);
        test_random_traffic(31, 31);
        in_ch.valid <= 1'b0;

        wait_drain();
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            mismatches += pending_results.size();
        end
        $display("Covered %0d requests, %0d results checked, %0d mismatches.",
                 requests_sent, results_checked, mismatches);
        $display("Outcomes: inserted %0d, kept %0d, replaced %0d, full %0d, popped %0d, empty %0d",
                 status_seen[ST_INSERTED], status_seen[ST_KEPT], status_seen[ST_REPLACED],
                 status_seen[ST_FULL], status_seen[ST_POPPED], status_seen[ST_EMPTY]);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
design/deq_pkg.sv
design/deq_if.sv
design/deq_cell.sv
design/deadline_ordered_event_queue_core.sv
bench/tb_deadline_ordered_event_queue_core.sv
